>>> sv/tftprp_pkg.sv
package tftprp_pkg;

	// Largest magnitude a converted value may reach.
	localparam logic [62:0] MagMax = {63{1'b1}};

	// Saturation point of the filename and mode length counters.
	localparam logic [10:0] LenCap = 11'd2047;

	// Bit positions of the recognised option keys.
	localparam int KeyBlkSize  = 0;
	localparam int KeyWinSize  = 1;
	localparam int KeyTimeout  = 2;
	localparam int KeyTranSize = 3;

	// Character codes used by the parser.
	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpZ   = 8'h5A;

	// Progress of the decimal value conversion.
	typedef enum logic [1:0] {
		NUM_LEAD,
		NUM_SIGN,
		NUM_DIGITS,
		NUM_DONE
	} num_phase_t;

	typedef struct packed {
		num_phase_t  phase;
		logic        negative;
		logic        saturated;
		logic [62:0] accum;
	} num_state_t;

	typedef struct packed {
		logic [3:0] cand;
		logic [3:0] idx;
	} key_state_t;

	typedef struct packed {
		logic [15:0] block_size_min;
		logic [15:0] block_size_max;
		logic [15:0] window_size_max;
		logic [7:0]  timeout_max;
	} cfg_t;

	typedef struct packed {
		logic        status;
		logic        is_write;
		logic [10:0] name_length;
		logic [10:0] mode_length;
		logic [3:0]  option_flags;
		logic [15:0] block_size;
		logic [15:0] window_size;
		logic [7:0]  timeout_seconds;
		logic [62:0] transfer_size;
	} result_t;

	// Register indexes of the configuration port.
	localparam logic [1:0] RegBlockSizeMin  = 2'd0;
	localparam logic [1:0] RegBlockSizeMax  = 2'd1;
	localparam logic [1:0] RegWindowSizeMax = 2'd2;
	localparam logic [1:0] RegTimeoutMax    = 2'd3;

	// Length of each option key.
	function automatic logic [3:0] key_len(input logic [1:0] k);
		logic [3:0] n;
		case (k)
			2'd0: n = 4'd7;
			2'd1: n = 4'd10;
			2'd2: n = 4'd7;
			2'd3: n = 4'd5;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// Character of a key at a given position, lower case; zero beyond its end.
	function automatic logic [7:0] key_char(input logic [1:0] k, input logic [3:0] idx);
		logic [79:0] txt;
		logic [3:0]  n;
		logic [3:0]  sh;
		logic [79:0] moved;
		case (k)
			2'd0: txt = 80'("blksize");
			2'd1: txt = 80'("windowsize");
			2'd2: txt = 80'("timeout");
			2'd3: txt = 80'("tsize");
			default: txt = '0;
		endcase
		n = key_len(k);
		sh = n - idx - 4'd1;
		moved = txt >> {sh, 3'b000};
		return (idx < n) ? moved[7:0] : 8'h00;
	endfunction

endpackage

>>> sv/tftprp_key_match.sv
module tftprp_key_match (
	input  logic [7:0]             data,
	input  tftprp_pkg::key_state_t key_cur,
	output tftprp_pkg::key_state_t key_fed,
	output logic [3:0]             cand_end
);

	logic [7:0] low;

	// Fold ASCII capitals to lower case before comparing.
	assign low = (data >= tftprp_pkg::ChUpA && data <= tftprp_pkg::ChUpZ) ?
		data + 8'h20 : data;

	// Drop every key that disagrees at this position, and advance the position counter, saturating at 15.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			key_fed.cand[k] = key_cur.cand[k]
				&& (key_cur.idx < tftprp_pkg::key_len(2'(k)))
				&& (low == tftprp_pkg::key_char(2'(k), key_cur.idx));
			cand_end[k] = key_cur.cand[k] && (key_cur.idx == tftprp_pkg::key_len(2'(k)));
		end
		key_fed.idx = (key_cur.idx == 4'hF) ? key_cur.idx : key_cur.idx + 4'd1;
	end

endmodule

>>> sv/tftprp_number.sv
module tftprp_number (
	input  logic [7:0]             data,
	input  tftprp_pkg::num_state_t num_cur,
	output tftprp_pkg::num_state_t num_nx
);

	logic        is_digit;
	logic        is_space;
	logic [3:0]  digit;
	logic [66:0] scaled;
	tftprp_pkg::num_state_t added;

	assign is_digit = data >= tftprp_pkg::ChZero && data <= tftprp_pkg::ChNine;
	assign is_space = data == tftprp_pkg::ChSpace
		|| (data >= tftprp_pkg::ChTab && data <= tftprp_pkg::ChCr);
	assign digit = 4'(data - tftprp_pkg::ChZero);

	// Times ten plus the digit, saturating once the magnitude passes the cap.
	assign scaled = {1'b0, num_cur.accum, 3'b000} + {3'b000, num_cur.accum, 1'b0}
		+ {63'd0, digit};

	always_comb begin
		added = num_cur;
		added.phase = tftprp_pkg::NUM_DIGITS;
		if (!num_cur.saturated) begin
			if (scaled > {4'd0, tftprp_pkg::MagMax}) begin
				added.accum = tftprp_pkg::MagMax;
				added.saturated = 1'b1;
			end else begin
				added.accum = scaled[62:0];
			end
		end
	end

	// Leading whitespace, one sign, then digits up to the first other character.
	always_comb begin
		num_nx = num_cur;
		case (num_cur.phase)
			tftprp_pkg::NUM_LEAD: begin
				if (is_space) begin
					num_nx = num_cur;
				end else if (data == tftprp_pkg::ChPlus || data == tftprp_pkg::ChMinus) begin
					num_nx.negative = data == tftprp_pkg::ChMinus;
					num_nx.phase = tftprp_pkg::NUM_SIGN;
				end else if (is_digit) begin
					num_nx = added;
				end else begin
					num_nx.phase = tftprp_pkg::NUM_DONE;
				end
			end
			tftprp_pkg::NUM_SIGN, tftprp_pkg::NUM_DIGITS: begin
				if (is_digit) begin
					num_nx = added;
				end else begin
					num_nx.phase = tftprp_pkg::NUM_DONE;
				end
			end
			default: num_nx = num_cur;
		endcase
	end

endmodule

>>> sv/tftprp_parser.sv
module tftprp_parser #(
	parameter int PACKET_MAX = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          data,
	input  logic                last,
	input  tftprp_pkg::cfg_t    cfg,
	output tftprp_pkg::result_t result
);

	localparam int PosW = $clog2(PACKET_MAX + 2);

	typedef enum logic [2:0] {
		PH_OPC_HI,
		PH_OPC_LO,
		PH_NAME,
		PH_MODE,
		PH_KEY,
		PH_VALUE
	} parse_phase_t;

	localparam tftprp_pkg::key_state_t KeyStart = '{cand: 4'hF, idx: 4'd0};
	localparam tftprp_pkg::num_state_t NumStart =
		'{phase: tftprp_pkg::NUM_LEAD, negative: 1'b0, saturated: 1'b0, accum: '0};

	parse_phase_t           phase_q, phase_nx;
	logic [PosW-1:0]        pos_q, pos_nx;
	logic [7:0]             opc_hi_q, opc_hi_nx;
	logic                   write_q, write_nx;
	logic [10:0]            name_cnt_q, name_cnt_nx;
	logic [10:0]            mode_cnt_q, mode_cnt_nx;
	tftprp_pkg::key_state_t key_q, key_nx, key_fed;
	logic [3:0]             cand_end;
	tftprp_pkg::num_state_t num_q, num_nx, num_fed;
	logic [15:0]            blk_q, blk_nx;
	logic [15:0]            win_q, win_nx;
	logic [7:0]             tmo_q, tmo_nx;
	logic [62:0]            tsz_q, tsz_nx;
	logic [3:0]             flags_q, flags_nx;
	logic                   reject_q, reject_nx;
	logic                   ok;
	logic [62:0]            x;

	tftprp_key_match u_key (
		.data     (data),
		.key_cur  (key_q),
		.key_fed  (key_fed),
		.cand_end (cand_end)
	);

	tftprp_number u_num (
		.data    (data),
		.num_cur (num_q),
		.num_nx  (num_fed)
	);

	assign x = num_q.accum;

	// Next parser state for the byte in hand.
	always_comb begin
		phase_nx = phase_q;
		opc_hi_nx = opc_hi_q;
		write_nx = write_q;
		name_cnt_nx = name_cnt_q;
		mode_cnt_nx = mode_cnt_q;
		key_nx = key_q;
		num_nx = num_q;
		blk_nx = blk_q;
		win_nx = win_q;
		tmo_nx = tmo_q;
		tsz_nx = tsz_q;
		flags_nx = flags_q;
		pos_nx = (pos_q <= PosW'(PACKET_MAX)) ? pos_q + PosW'(1) : pos_q;
		reject_nx = reject_q || (pos_q >= PosW'(PACKET_MAX));
		if (!reject_nx) begin
			case (phase_q)
				PH_OPC_HI: begin
					opc_hi_nx = data;
					phase_nx = PH_OPC_LO;
				end
				PH_OPC_LO: begin
					if (opc_hi_q != 8'd0 || (data != 8'd1 && data != 8'd2)) begin
						reject_nx = 1'b1;
					end else begin
						write_nx = data == 8'd2;
						phase_nx = PH_NAME;
					end
				end
				PH_NAME: begin
					if (data == tftprp_pkg::ChNul) begin
						phase_nx = PH_MODE;
					end else if (name_cnt_q < tftprp_pkg::LenCap) begin
						name_cnt_nx = name_cnt_q + 11'd1;
					end
				end
				PH_MODE: begin
					if (data == tftprp_pkg::ChNul) begin
						phase_nx = PH_KEY;
						key_nx = KeyStart;
					end else if (mode_cnt_q < tftprp_pkg::LenCap) begin
						mode_cnt_nx = mode_cnt_q + 11'd1;
					end
				end
				PH_KEY: begin
					if (data == tftprp_pkg::ChNul) begin
						key_nx.cand = cand_end;
						num_nx = NumStart;
						phase_nx = PH_VALUE;
					end else begin
						key_nx = key_fed;
					end
				end
				PH_VALUE: begin
					if (data == tftprp_pkg::ChNul) begin
						// Keep the value when it lies within the limits of its key.
						if (!(num_q.negative && x != '0)) begin
							if (key_q.cand[tftprp_pkg::KeyBlkSize]) begin
								if (x >= {47'd0, cfg.block_size_min}
										&& x <= {47'd0, cfg.block_size_max}) begin
									blk_nx = x[15:0];
									flags_nx[tftprp_pkg::KeyBlkSize] = 1'b1;
								end
							end else if (key_q.cand[tftprp_pkg::KeyWinSize]) begin
								if (x >= 63'd1 && x <= {47'd0, cfg.window_size_max}) begin
									win_nx = x[15:0];
									flags_nx[tftprp_pkg::KeyWinSize] = 1'b1;
								end
							end else if (key_q.cand[tftprp_pkg::KeyTimeout]) begin
								if (x >= 63'd1 && x <= {55'd0, cfg.timeout_max}) begin
									tmo_nx = x[7:0];
									flags_nx[tftprp_pkg::KeyTimeout] = 1'b1;
								end
							end else if (key_q.cand[tftprp_pkg::KeyTranSize]) begin
								tsz_nx = x;
								flags_nx[tftprp_pkg::KeyTranSize] = 1'b1;
							end
						end
						key_nx = KeyStart;
						phase_nx = PH_KEY;
					end else begin
						num_nx = num_fed;
					end
				end
				default: phase_nx = phase_q;
			endcase
		end
	end

	// Result of a packet that ends with this byte.
	always_comb begin
		ok = !reject_nx && pos_nx >= PosW'(4) && (phase_nx == PH_KEY || phase_nx == PH_VALUE);
		result = '0;
		result.status = !ok;
		if (ok) begin
			result.is_write = write_nx;
			result.name_length = name_cnt_nx;
			result.mode_length = mode_cnt_nx;
			result.option_flags = flags_nx;
			result.block_size = blk_nx;
			result.window_size = win_nx;
			result.timeout_seconds = tmo_nx;
			result.transfer_size = tsz_nx;
		end
	end

	// Parser state; it starts afresh after the last byte of each packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPC_HI;
			pos_q <= '0;
			opc_hi_q <= '0;
			write_q <= 1'b0;
			name_cnt_q <= '0;
			mode_cnt_q <= '0;
			key_q <= KeyStart;
			num_q <= NumStart;
			blk_q <= '0;
			win_q <= '0;
			tmo_q <= '0;
			tsz_q <= '0;
			flags_q <= '0;
			reject_q <= 1'b0;
		end else if (fire && last) begin
			phase_q <= PH_OPC_HI;
			pos_q <= '0;
			opc_hi_q <= '0;
			write_q <= 1'b0;
			name_cnt_q <= '0;
			mode_cnt_q <= '0;
			key_q <= KeyStart;
			num_q <= NumStart;
			blk_q <= '0;
			win_q <= '0;
			tmo_q <= '0;
			tsz_q <= '0;
			flags_q <= '0;
			reject_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_nx;
			pos_q <= pos_nx;
			opc_hi_q <= opc_hi_nx;
			write_q <= write_nx;
			name_cnt_q <= name_cnt_nx;
			mode_cnt_q <= mode_cnt_nx;
			key_q <= key_nx;
			num_q <= num_nx;
			blk_q <= blk_nx;
			win_q <= win_nx;
			tmo_q <= tmo_nx;
			tsz_q <= tsz_nx;
			flags_q <= flags_nx;
			reject_q <= reject_nx;
		end
	end

endmodule

>>> sv/tftp_request_parser.sv
// TFTP read/write request parser.
// Request bytes enter on the req channel, one byte per transaction, with
// last_byte marking the final byte of a packet. One result transaction
// leaves on the res channel for each packet: status 0 with the opcode kind,
// filename and mode lengths and the accepted options, or status 1 with all
// other fields zero.
// A byte is taken every cycle while req_stall is low. Each byte passes an
// input register and is then parsed; the result of a packet is loaded into
// the output register when its last byte leaves the input register.
// The output register lets parsing go on while a result waits. Only when a
// further last byte reaches the parser while the waiting result is stalled
// does req_stall rise, holding the input register until res_stall falls.
// Reset clears the parser to the start of a packet, empties both registers and
// loads the limit registers with their defaults (block size 8..65464, window size
// up to 65535, timeout up to 255). The cfg port writes a limit register at each clock
// edge with cfg_we high; the user must write only while idle, unchecked by the block.
module tftp_request_parser #(
	parameter int PACKET_MAX = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        status,
	output logic        is_write,
	output logic [10:0] name_length,
	output logic [10:0] mode_length,
	output logic [3:0]  option_flags,
	output logic [15:0] block_size,
	output logic [15:0] window_size,
	output logic [7:0]  timeout_seconds,
	output logic [62:0] transfer_size,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic                valid_s1;
	logic [7:0]          data_s1;
	logic                last_s1;
	logic                fire;
	tftprp_pkg::cfg_t    cfg_q;
	tftprp_pkg::result_t result;
	tftprp_pkg::result_t res_q;
	logic                res_valid_q;

	// The parser holds its byte only when it ends a packet and the result slot is stalled.
	assign req_stall = valid_s1 && last_s1 && res_valid_q && res_stall;
	assign fire = valid_s1 && !req_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size_min <= 16'd8;
			cfg_q.block_size_max <= 16'd65464;
			cfg_q.window_size_max <= 16'd65535;
			cfg_q.timeout_max <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				tftprp_pkg::RegBlockSizeMin: cfg_q.block_size_min <= cfg_data;
				tftprp_pkg::RegBlockSizeMax: cfg_q.block_size_max <= cfg_data;
				tftprp_pkg::RegWindowSizeMax: cfg_q.window_size_max <= cfg_data;
				tftprp_pkg::RegTimeoutMax: cfg_q.timeout_max <= cfg_data[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	tftprp_parser #(
		.PACKET_MAX (PACKET_MAX)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.data   (data_s1),
		.last   (last_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign status = res_q.status;
	assign is_write = res_q.is_write;
	assign name_length = res_q.name_length;
	assign mode_length = res_q.mode_length;
	assign option_flags = res_q.option_flags;
	assign block_size = res_q.block_size;
	assign window_size = res_q.window_size;
	assign timeout_seconds = res_q.timeout_seconds;
	assign transfer_size = res_q.transfer_size;

endmodule
